FILE: hdl/stereo_angle_triangulation_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the stereo triangulation checker
// Implication and never-true checks on clk, reset by arst_n.
// ----------------------------------------------------------------------------
`ifndef STEREO_ANGLE_TRIANGULATION_TOP_ASSERT_SVH
`define STEREO_ANGLE_TRIANGULATION_TOP_ASSERT_SVH

// ante implies cons in the same cycle
`define SATRI_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("stereo triangulation: implication check failed");

// expr never holds
`define SATRI_ASSERT_NEVER(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error("stereo triangulation: forbidden condition seen");

`endif

FILE: hdl/satri_pkg.sv
// ----------------------------------------------------------------------------
// satri_pkg
// Constants, types and arithmetic helpers of the stereo triangulation block.
// ----------------------------------------------------------------------------
package satri_pkg;

	localparam int ANGLE_FRAC_BITS = 16;
	localparam int CORDIC_STAGES   = 16;
	localparam int DIV_QW          = 18;
	localparam int PIPE_LAT        = CORDIC_STAGES + DIV_QW + 10;

	localparam int MAG_W  = 34;
	localparam int LO_W   = 17;
	localparam int HI_W   = MAG_W - LO_W;
	localparam int C_W    = 27;
	localparam int PH_W   = HI_W + C_W;
	localparam int PL_W   = LO_W + C_W;
	localparam int PP_W   = MAG_W + C_W + 1;
	localparam int SH_D   = 56 - ANGLE_FRAC_BITS;
	localparam int SH_M   = SH_D + 1;
	localparam int RAD_W  = ANGLE_FRAC_BITS + 6;
	localparam int Q30_SH = 30 - ANGLE_FRAC_BITS;
	localparam int XY_W   = 34;
	localparam int Z_W    = 36;
	localparam int NUM_W  = 53;
	localparam int DEN_W  = 42;
	localparam int CMP_W  = DEN_W + DIV_QW;
	localparam int MP_W   = XY_W + 19;
	localparam int POS_W  = 19;

	localparam logic [C_W-1:0] DEG_RAD_Q32 = 27'd74961321;
	localparam logic signed [Z_W-1:0] PI_Q30      = 36'sd3373259426;
	localparam logic signed [Z_W-1:0] HALF_PI_Q30 = 36'sd1686629713;
	localparam logic signed [XY_W-1:0] GAIN_Q30   = 34'sd652032874;

	localparam int FAR_LIM   = ((2 ** ANGLE_FRAC_BITS) - 1) / 100;
	localparam int SMALL_LIM = ((2 ** ANGLE_FRAC_BITS) - 1) / 10;
	localparam int POS_LIMIT = 200000;
	localparam int FAR_MM    = 10000;

	typedef enum logic [2:0] {
		ST_OK    = 3'd0,
		ST_FAR   = 3'd1,
		ST_TEMP  = 3'd2,
		ST_LEFT  = 3'd3,
		ST_RIGHT = 3'd4,
		ST_NONE  = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		REG_HFOV  = 3'd0,
		REG_VFOV  = 3'd1,
		REG_BASE  = 3'd2,
		REG_TLIM  = 3'd3
	} cfg_reg_t;

	typedef struct packed {
		logic signed [XY_W-1:0] x;
		logic signed [XY_W-1:0] y;
		logic signed [Z_W-1:0]  z;
	} crd_t;

	typedef struct packed {
		status_t          st;
		logic             narrow;
		logic [RAD_W-1:0] mag;
		logic             neg_d;
		logic             neg_a;
		logic             neg_e;
	} cside_t;

	typedef struct packed {
		status_t                st;
		logic                   dzero;
		logic                   dsat;
		logic signed [XY_W-1:0] cc;
		logic signed [XY_W-1:0] sc;
		logic signed [XY_W-1:0] se;
	} dside_t;

	typedef struct packed {
		logic [NUM_W-1:0]  rem;
		logic [DEN_W-1:0]  den;
		logic [DIV_QW-1:0] q;
		logic              ovf;
	} dv_t;

	function automatic logic signed [Z_W-1:0] atan_q30(input int i);
		logic signed [Z_W-1:0] a;
		case (i)
			0:  a = 36'sd843314857;
			1:  a = 36'sd497837829;
			2:  a = 36'sd263043837;
			3:  a = 36'sd133525159;
			4:  a = 36'sd67021687;
			5:  a = 36'sd33543516;
			6:  a = 36'sd16775851;
			7:  a = 36'sd8388437;
			8:  a = 36'sd4194283;
			9:  a = 36'sd2097149;
			10: a = 36'sd1048576;
			11: a = 36'sd524288;
			12: a = 36'sd262144;
			13: a = 36'sd131072;
			14: a = 36'sd65536;
			15: a = 36'sd32768;
			16: a = 36'sd16384;
			17: a = 36'sd8192;
			18: a = 36'sd4096;
			19: a = 36'sd2048;
			20: a = 36'sd1024;
			21: a = 36'sd512;
			22: a = 36'sd256;
			23: a = 36'sd128;
			default: a = '0;
		endcase
		return a;
	endfunction

	// fold into +-pi/2; msb flags a half-turn move
	function automatic logic [Z_W:0] fold_ang(input logic signed [Z_W-1:0] ang);
		logic [Z_W:0] r;
		if (ang > HALF_PI_Q30)
			r = {1'b1, ang - PI_Q30};
		else if (ang < -HALF_PI_Q30)
			r = {1'b1, ang + PI_Q30};
		else
			r = {1'b0, ang};
		return r;
	endfunction

	function automatic crd_t cordic_init(input logic signed [Z_W-1:0] z);
		crd_t c;
		c.x = GAIN_Q30;
		c.y = '0;
		c.z = z;
		return c;
	endfunction

	function automatic crd_t cordic_step(input crd_t c, input int i);
		crd_t r;
		logic signed [XY_W-1:0] dx;
		logic signed [XY_W-1:0] dy;
		dx = c.y >>> i;
		dy = c.x >>> i;
		if (!c.z[Z_W-1]) begin
			r.x = c.x - dx;
			r.y = c.y + dy;
			r.z = c.z - atan_q30(i);
		end else begin
			r.x = c.x + dx;
			r.y = c.y - dy;
			r.z = c.z + atan_q30(i);
		end
		return r;
	endfunction

	function automatic logic signed [XY_W-1:0] mul_q30(input logic signed [XY_W-1:0] a,
			input logic signed [XY_W-1:0] b);
		logic signed [2*XY_W-1:0] p;
		p = (2*XY_W)'(a) * (2*XY_W)'(b);
		p = p + (2*XY_W)'(64'sd536870912);
		return XY_W'(p >>> 30);
	endfunction

	function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [MP_W-1:0] v);
		logic signed [POS_W-1:0] r;
		if (v > MP_W'(POS_LIMIT))
			r = POS_W'(POS_LIMIT);
		else if (v < -MP_W'(POS_LIMIT))
			r = -POS_W'(POS_LIMIT);
		else
			r = POS_W'(v);
		return r;
	endfunction

endpackage

FILE: hdl/stereo_angle_triangulation_top.sv
// ----------------------------------------------------------------------------
// stereo_angle_triangulation_top
// Stereo hot-spot triangulation: camera pair angles, disparity distance,
// camera-frame position in mm with status.
// ----------------------------------------------------------------------------
//  channel   handshake               payload
//  input     start & !busy           left/right fresh, peak temp, col, row
//  result    done (one cycle)        status, pos_forward/lateral/vertical_mm
//  config    cfg_valid & cfg_ready   cfg_index, cfg_data
//
//  One item per cycle; the result passes through the CORDIC stages and the 18
//  restoring divider steps before done is raised.
//  busy stays low; the pipeline never stalls and the receiver cannot stall.
//  Reset clears valid bits and restores the configuration registers.
module stereo_angle_triangulation_top
	import satri_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic                    left_fresh,
	input  logic                    right_fresh,
	input  logic signed [15:0]      left_peak_temp,
	input  logic signed [15:0]      right_peak_temp,
	input  logic [15:0]             left_col,
	input  logic [15:0]             left_row,
	input  logic [15:0]             right_col,
	input  logic [15:0]             right_row,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [2:0]              cfg_index,
	input  logic [19:0]             cfg_data,
	output logic                    done,
	output logic [2:0]              status,
	output logic signed [POS_W-1:0] pos_forward_mm,
	output logic signed [POS_W-1:0] pos_lateral_mm,
	output logic signed [POS_W-1:0] pos_vertical_mm
);

	logic [15:0] hfov_q, vfov_q;
	logic [19:0] base_q;
	logic [14:0] tlim_q;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hfov_q <= 16'd12800;
			vfov_q <= 16'd9523;
			base_q <= 20'd294000;
			tlim_q <= 15'd50;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_HFOV: hfov_q <= cfg_data[15:0];
				REG_VFOV: vfov_q <= cfg_data[15:0];
				REG_BASE: base_q <= cfg_data;
				REG_TLIM: tlim_q <= cfg_data[14:0];
				default: ;
			endcase
		end
	end

	// stage 1: classify, view products
	logic signed [16:0] tdiff, lc_c, rc_c, lr_c, rr_c;
	logic [16:0] tabs;
	status_t st_c;
	logic v_s1;
	status_t st_s1;
	logic signed [MAG_W-1:0] laz_s1, raz_s1, lel_s1, rel_s1;

	always_comb begin
		tdiff = 17'({left_peak_temp[15], left_peak_temp}) -
			17'({right_peak_temp[15], right_peak_temp});
		tabs  = tdiff[16] ? 17'(-tdiff) : 17'(tdiff);
		lc_c  = $signed({1'b0, left_col}) - 17'sd32768;
		rc_c  = $signed({1'b0, right_col}) - 17'sd32768;
		lr_c  = 17'sd32768 - $signed({1'b0, left_row});
		rr_c  = 17'sd32768 - $signed({1'b0, right_row});
		if (left_fresh && right_fresh)
			st_c = (tabs > {2'b00, tlim_q}) ? ST_TEMP : ST_OK;
		else if (left_fresh)
			st_c = ST_LEFT;
		else if (right_fresh)
			st_c = ST_RIGHT;
		else
			st_c = ST_NONE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else
			v_s1 <= start && !busy;
	end

	always_ff @(posedge clk) begin
		st_s1  <= st_c;
		laz_s1 <= MAG_W'(lc_c) * MAG_W'($signed({1'b0, hfov_q}));
		raz_s1 <= MAG_W'(rc_c) * MAG_W'($signed({1'b0, hfov_q}));
		lel_s1 <= MAG_W'(lr_c) * MAG_W'($signed({1'b0, vfov_q}));
		rel_s1 <= MAG_W'(rr_c) * MAG_W'($signed({1'b0, vfov_q}));
	end

	// stage 2: disparity and sums, magnitudes
	logic signed [MAG_W:0] dsum, asum, esum;
	logic v_s2;
	status_t st_s2;
	logic [MAG_W-1:0] dmag_s2, amag_s2, emag_s2;
	logic aneg_s2, eneg_s2;

	always_comb begin
		dsum = (MAG_W+1)'(laz_s1) - (MAG_W+1)'(raz_s1);
		asum = (MAG_W+1)'(laz_s1) + (MAG_W+1)'(raz_s1);
		esum = (MAG_W+1)'(lel_s1) + (MAG_W+1)'(rel_s1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s2 <= 1'b0;
		else
			v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		st_s2   <= st_s1;
		aneg_s2 <= asum[MAG_W];
		eneg_s2 <= esum[MAG_W];
		dmag_s2 <= dsum[MAG_W] ? MAG_W'(-dsum) : MAG_W'(dsum);
		amag_s2 <= asum[MAG_W] ? MAG_W'(-asum) : MAG_W'(asum);
		emag_s2 <= esum[MAG_W] ? MAG_W'(-esum) : MAG_W'(esum);
	end

	// stage 3: degree to radian partial products
	logic v_s3;
	status_t st_s3;
	logic aneg_s3, eneg_s3;
	logic [PH_W-1:0] dph_s3, aph_s3, eph_s3;
	logic [PL_W-1:0] dpl_s3, apl_s3, epl_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s3 <= 1'b0;
		else
			v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		st_s3   <= st_s2;
		aneg_s3 <= aneg_s2;
		eneg_s3 <= eneg_s2;
		dph_s3  <= dmag_s2[MAG_W-1:LO_W] * DEG_RAD_Q32;
		aph_s3  <= amag_s2[MAG_W-1:LO_W] * DEG_RAD_Q32;
		eph_s3  <= emag_s2[MAG_W-1:LO_W] * DEG_RAD_Q32;
		dpl_s3  <= dmag_s2[LO_W-1:0] * DEG_RAD_Q32;
		apl_s3  <= amag_s2[LO_W-1:0] * DEG_RAD_Q32;
		epl_s3  <= emag_s2[LO_W-1:0] * DEG_RAD_Q32;
	end

	// stage 4: combine, round, classify disparity
	logic [PP_W-1:0] dfull, afull, efull;
	logic [RAD_W-1:0] drad, arad, erad;
	logic v_s4;
	status_t st_s4;
	logic small_s4, aneg_s4, eneg_s4;
	logic [RAD_W-1:0] drad_s4, arad_s4, erad_s4;

	always_comb begin
		dfull = (PP_W'(dph_s3) << LO_W) + PP_W'(dpl_s3) + (PP_W'(1) << (SH_D - 1));
		afull = (PP_W'(aph_s3) << LO_W) + PP_W'(apl_s3) + (PP_W'(1) << (SH_M - 1));
		efull = (PP_W'(eph_s3) << LO_W) + PP_W'(epl_s3) + (PP_W'(1) << (SH_M - 1));
		drad  = RAD_W'(dfull >> SH_D);
		arad  = RAD_W'(afull >> SH_M);
		erad  = RAD_W'(efull >> SH_M);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s4 <= 1'b0;
		else
			v_s4 <= v_s3;
	end

	always_ff @(posedge clk) begin
		st_s4    <= (st_s3 == ST_OK && drad <= RAD_W'(FAR_LIM)) ? ST_FAR : st_s3;
		small_s4 <= drad <= RAD_W'(SMALL_LIM);
		aneg_s4  <= aneg_s3;
		eneg_s4  <= eneg_s3;
		drad_s4  <= drad;
		arad_s4  <= arad;
		erad_s4  <= erad;
	end

	// stage 5: Q30 angles folded into +-pi/2, CORDIC entry
	logic signed [Z_W-1:0] zd, za, ze, za_u, ze_u;
	logic [Z_W:0] fd, fa, fe;

	crd_t   cd_s [0:CORDIC_STAGES];
	crd_t   ca_s [0:CORDIC_STAGES];
	crd_t   ce_s [0:CORDIC_STAGES];
	cside_t cs_s [0:CORDIC_STAGES];
	logic   cv_s [0:CORDIC_STAGES];

	always_comb begin
		zd   = $signed((Z_W'(drad_s4) << Q30_SH) >> 1);
		za_u = $signed(Z_W'(arad_s4) << Q30_SH);
		ze_u = $signed(Z_W'(erad_s4) << Q30_SH);
		za   = aneg_s4 ? -za_u : za_u;
		ze   = eneg_s4 ? -ze_u : ze_u;
		fd   = fold_ang(zd);
		fa   = fold_ang(za);
		fe   = fold_ang(ze);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			cv_s[0] <= 1'b0;
		else
			cv_s[0] <= v_s4;
	end

	always_ff @(posedge clk) begin
		cd_s[0]        <= cordic_init($signed(fd[Z_W-1:0]));
		ca_s[0]        <= cordic_init($signed(fa[Z_W-1:0]));
		ce_s[0]        <= cordic_init($signed(fe[Z_W-1:0]));
		cs_s[0].st     <= st_s4;
		cs_s[0].narrow <= small_s4;
		cs_s[0].mag    <= drad_s4;
		cs_s[0].neg_d  <= fd[Z_W];
		cs_s[0].neg_a  <= fa[Z_W];
		cs_s[0].neg_e  <= fe[Z_W];
	end

	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_crd
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				cv_s[i+1] <= 1'b0;
			else
				cv_s[i+1] <= cv_s[i];
		end

		always_ff @(posedge clk) begin
			cd_s[i+1] <= cordic_step(cd_s[i], i);
			ca_s[i+1] <= cordic_step(ca_s[i], i);
			ce_s[i+1] <= cordic_step(ce_s[i], i);
			cs_s[i+1] <= cs_s[i];
		end
	end

	// stage 6: divider operands, direction products
	cside_t ce;
	logic signed [XY_W-1:0] sh_c, ch_c, saz_c, caz_c, sel_c, cel_c;
	logic [NUM_W-1:0] num_c;
	logic [DEN_W-1:0] den_c;
	logic v_s6;
	dside_t ds_s6;
	logic [NUM_W-1:0] num_s6;
	logic [DEN_W-1:0] den_s6;

	always_comb begin
		ce    = cs_s[CORDIC_STAGES];
		sh_c  = ce.neg_d ? -cd_s[CORDIC_STAGES].y : cd_s[CORDIC_STAGES].y;
		ch_c  = ce.neg_d ? -cd_s[CORDIC_STAGES].x : cd_s[CORDIC_STAGES].x;
		saz_c = ce.neg_a ? -ca_s[CORDIC_STAGES].y : ca_s[CORDIC_STAGES].y;
		caz_c = ce.neg_a ? -ca_s[CORDIC_STAGES].x : ca_s[CORDIC_STAGES].x;
		sel_c = ce.neg_e ? -ce_s[CORDIC_STAGES].y : ce_s[CORDIC_STAGES].y;
		cel_c = ce.neg_e ? -ce_s[CORDIC_STAGES].x : ce_s[CORDIC_STAGES].x;
		if (ce.narrow) begin
			num_c = (NUM_W'(base_q) << ANGLE_FRAC_BITS) + NUM_W'(ce.mag) * NUM_W'(500);
			den_c = DEN_W'(ce.mag) * DEN_W'(1000);
		end else begin
			num_c = NUM_W'(base_q) * NUM_W'(ch_c[XY_W-2:0]) +
				NUM_W'(sh_c[XY_W-2:0]) * NUM_W'(1000);
			den_c = DEN_W'(sh_c[XY_W-2:0]) * DEN_W'(2000);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s6 <= 1'b0;
		else
			v_s6 <= cv_s[CORDIC_STAGES];
	end

	always_ff @(posedge clk) begin
		ds_s6.st    <= ce.st;
		ds_s6.dzero <= !ce.narrow && ch_c <= 0;
		ds_s6.dsat  <= !ce.narrow && sh_c <= 0;
		ds_s6.cc    <= mul_q30(caz_c, cel_c);
		ds_s6.sc    <= mul_q30(saz_c, cel_c);
		ds_s6.se    <= sel_c;
		num_s6      <= num_c;
		den_s6      <= den_c;
	end

	// restoring divider, one quotient bit per stage
	dv_t    dv_s  [0:DIV_QW];
	dside_t dsd_s [0:DIV_QW];
	logic   dvv_s [0:DIV_QW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			dvv_s[0] <= 1'b0;
		else
			dvv_s[0] <= v_s6;
	end

	always_ff @(posedge clk) begin
		dv_s[0].rem <= num_s6;
		dv_s[0].den <= den_s6;
		dv_s[0].q   <= '0;
		dv_s[0].ovf <= CMP_W'(num_s6) >= (CMP_W'(den_s6) << DIV_QW);
		dsd_s[0]    <= ds_s6;
	end

	for (genvar j = 0; j < DIV_QW; j++) begin : g_div
		localparam int B = DIV_QW - 1 - j;
		logic [CMP_W-1:0] trial;
		logic take;

		always_comb begin
			trial = CMP_W'(dv_s[j].den) << B;
			take  = CMP_W'(dv_s[j].rem) >= trial;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				dvv_s[j+1] <= 1'b0;
			else
				dvv_s[j+1] <= dvv_s[j];
		end

		always_ff @(posedge clk) begin
			dv_s[j+1].rem <= take ? NUM_W'(CMP_W'(dv_s[j].rem) - trial) : dv_s[j].rem;
			dv_s[j+1].den <= dv_s[j].den;
			dv_s[j+1].q   <= dv_s[j].q | (take ? (DIV_QW'(1) << B) : '0);
			dv_s[j+1].ovf <= dv_s[j].ovf;
			dsd_s[j+1]    <= dsd_s[j];
		end
	end

	// stage 7: distance
	dside_t dq;
	logic [DIV_QW-1:0] dist_c;
	logic v_s7;
	dside_t ds_s7;
	logic [DIV_QW-1:0] dist_s7;

	always_comb begin
		dq = dsd_s[DIV_QW];
		if (dq.dzero)
			dist_c = '0;
		else if (dq.dsat || dv_s[DIV_QW].ovf || dv_s[DIV_QW].q > DIV_QW'(POS_LIMIT))
			dist_c = DIV_QW'(POS_LIMIT);
		else
			dist_c = dv_s[DIV_QW].q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s7 <= 1'b0;
		else
			v_s7 <= dvv_s[DIV_QW];
	end

	always_ff @(posedge clk) begin
		ds_s7   <= dq;
		dist_s7 <= dist_c;
	end

	// stage 8: position products
	logic signed [MP_W-1:0] dist_x;
	logic v_s8;
	status_t st_s8;
	logic signed [MP_W-1:0] pf_s8, pl_s8, pv_s8;

	assign dist_x = MP_W'($signed({1'b0, dist_s7}));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s8 <= 1'b0;
		else
			v_s8 <= v_s7;
	end

	always_ff @(posedge clk) begin
		st_s8 <= ds_s7.st;
		pf_s8 <= dist_x * MP_W'(ds_s7.cc) + MP_W'(64'sd536870912);
		pl_s8 <= dist_x * MP_W'(ds_s7.sc) + MP_W'(64'sd536870912);
		pv_s8 <= dist_x * MP_W'(ds_s7.se) + MP_W'(64'sd536870912);
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			done <= 1'b0;
		else
			done <= v_s8;
	end

	always_ff @(posedge clk) begin
		status <= st_s8;
		case (st_s8)
			ST_OK: begin
				pos_forward_mm  <= sat_pos(pf_s8 >>> 30);
				pos_lateral_mm  <= sat_pos(pl_s8 >>> 30);
				pos_vertical_mm <= sat_pos(pv_s8 >>> 30);
			end
			ST_FAR: begin
				pos_forward_mm  <= '0;
				pos_lateral_mm  <= '0;
				pos_vertical_mm <= POS_W'(FAR_MM);
			end
			default: begin
				pos_forward_mm  <= '0;
				pos_lateral_mm  <= '0;
				pos_vertical_mm <= '0;
			end
		endcase
	end

endmodule

FILE: hdl/satri_chk.sv
// ----------------------------------------------------------------------------
// satri_chk
// Port-level checks of the stereo triangulation block, bound to the top level.
// ----------------------------------------------------------------------------
`include "stereo_angle_triangulation_top_assert.svh"

module satri_chk
	import satri_pkg::*;
(
	input logic                    clk,
	input logic                    arst_n,
	input logic                    start,
	input logic                    busy,
	input logic                    done,
	input logic [2:0]              status,
	input logic signed [POS_W-1:0] pos_forward_mm,
	input logic signed [POS_W-1:0] pos_lateral_mm,
	input logic signed [POS_W-1:0] pos_vertical_mm
);

	logic xy_zero;
	logic rejected;

	assign xy_zero  = pos_forward_mm == '0 && pos_lateral_mm == '0;
	assign rejected = status == ST_TEMP || status == ST_LEFT ||
		status == ST_RIGHT || status == ST_NONE;

	`SATRI_ASSERT_IMP(a_done_after_transfer, done, $past(start && !busy, PIPE_LAT))
	`SATRI_ASSERT_NEVER(a_status_code, done && status > ST_NONE)
	`SATRI_ASSERT_IMP(a_far_position, done && status == ST_FAR, xy_zero && pos_vertical_mm == POS_W'(FAR_MM))
	`SATRI_ASSERT_IMP(a_reject_zero, done && rejected, xy_zero && pos_vertical_mm == '0)

endmodule

bind stereo_angle_triangulation_top satri_chk u_satri_chk (.*);

FILE: dv/stereo_angle_triangulation_top_tb.sv
// ----------------------------------------------------------------------------
// stereo_angle_triangulation_top_tb
// Self-checking bench: directed table plus random measurement pairs under
// several field-of-view, baseline and temperature-limit settings, each result
// compared against its directed table entry or a bit-accurate position predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stereo_angle_triangulation_top_tb;
	import satri_pkg::*;

	typedef struct {
		logic        lv;
		logic        rv;
		logic [15:0] lt;
		logic [15:0] rt;
		logic [15:0] lc;
		logic [15:0] lr;
		logic [15:0] rc;
		logic [15:0] rr;
	} meas_t;

	typedef struct {
		status_t     st;
		logic [18:0] fwd;
		logic [18:0] lat;
		logic [18:0] vert;
	} pos_t;

	typedef struct {
		meas_t m;
		logic  typed;
		pos_t  p;
	} row_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic        left_fresh;
	logic        right_fresh;
	logic [15:0] left_peak_temp;
	logic [15:0] right_peak_temp;
	logic [15:0] left_col;
	logic [15:0] left_row;
	logic [15:0] right_col;
	logic [15:0] right_row;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [19:0] cfg_data;
	logic        done;
	logic [2:0]  status;
	logic signed [POS_W-1:0] pos_forward_mm;
	logic signed [POS_W-1:0] pos_lateral_mm;
	logic signed [POS_W-1:0] pos_vertical_mm;

	longint hfov, vfov, base_um, tlim;
	pos_t   pos_q[$];
	int     errs;

	localparam longint ATAN[24] = '{843314857, 497837829, 263043837, 133525159, 67021687,
		33543516, 16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072,
		65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128};

	stereo_angle_triangulation_top uut (.*);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#2ms;
		$display("stereo_angle_triangulation_top regression: fail");
		$finish;
	end

	function automatic longint ang_rad(longint v, int extra);
		int sh;
		longint unsigned mag, r;
		sh = 56 - ANGLE_FRAC_BITS + extra;
		mag = v < 0 ? -v : v;
		r = (mag * 64'd74961321 + (64'd1 << (sh - 1))) >> sh;
		return v < 0 ? -longint'(r) : longint'(r);
	endfunction

	function automatic longint qmul(longint a, longint b);
		return (a * b + (64'sd1 <<< 29)) >>> 30;
	endfunction

	function automatic longint clip(longint v);
		return v > POS_LIMIT ? POS_LIMIT : (v < -POS_LIMIT ? -POS_LIMIT : v);
	endfunction

	task automatic rot_sincos(input longint ang, output longint s, output longint c);
		logic   flip;
		longint x, y, dx, dy;
		flip = 1'b0;
		if (ang > 64'sd1686629713) begin
			ang -= 64'sd3373259426;
			flip = 1'b1;
		end else if (ang < -64'sd1686629713) begin
			ang += 64'sd3373259426;
			flip = 1'b1;
		end
		x = 652032874;
		y = 0;
		for (int i = 0; i < CORDIC_STAGES && i < 24; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (ang >= 0) begin
				x -= dx; y += dy; ang -= ATAN[i];
			end else begin
				x += dx; y -= dy; ang += ATAN[i];
			end
		end
		s = flip ? -y : y;
		c = flip ? -x : x;
	endtask

	task automatic locate(input meas_t m, output pos_t p);
		longint lt, rt, laz, raz, lel, rel, dq, rng_mm, sh, ch, saz, caz, sel, cel, h30;
		longint unsigned mag, one;
		lt = longint'($signed(m.lt));
		rt = longint'($signed(m.rt));
		p.fwd = '0;
		p.lat = '0;
		p.vert = '0;
		one = 64'd1 << ANGLE_FRAC_BITS;
		if (m.lv && m.rv) begin
			if ((lt > rt ? lt - rt : rt - lt) > tlim) begin
				p.st = ST_TEMP;
			end else begin
				laz = (longint'(m.lc) - 32768) * hfov;
				raz = (longint'(m.rc) - 32768) * hfov;
				lel = (32768 - longint'(m.lr)) * vfov;
				rel = (32768 - longint'(m.rr)) * vfov;
				dq = ang_rad(laz - raz, 0);
				mag = dq < 0 ? -dq : dq;
				if (mag * 100 < one) begin
					p.st = ST_FAR;
					p.vert = 19'(FAR_MM);
				end else begin
					p.st = ST_OK;
					if (mag * 10 < one) begin
						rng_mm = ((longint'(base_um) << ANGLE_FRAC_BITS) + 500 * mag) /
							(1000 * mag);
					end else begin
						h30 = longint'((mag << (30 - ANGLE_FRAC_BITS)) >> 1);
						rot_sincos(h30, sh, ch);
						if (ch <= 0) rng_mm = 0;
						else if (sh <= 0) rng_mm = POS_LIMIT;
						else rng_mm = (base_um * ch + 1000 * sh) / (2000 * sh);
					end
					if (rng_mm > POS_LIMIT) rng_mm = POS_LIMIT;
					rot_sincos(ang_rad(laz + raz, 1) * (64'sd1 <<< Q30_SH), saz, caz);
					rot_sincos(ang_rad(lel + rel, 1) * (64'sd1 <<< Q30_SH), sel, cel);
					p.fwd = 19'(clip(qmul(rng_mm, qmul(caz, cel))));
					p.lat = 19'(clip(qmul(rng_mm, qmul(saz, cel))));
					p.vert = 19'(clip(qmul(rng_mm, sel)));
				end
			end
		end else if (m.lv) begin
			p.st = ST_LEFT;
		end else if (m.rv) begin
			p.st = ST_RIGHT;
		end else begin
			p.st = ST_NONE;
		end
	endtask

	task automatic report(input string what, input longint got, input longint want);
		$display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
		errs++;
	endtask

	always @(posedge clk) begin
		pos_t e;
		if (arst_n && done) begin
			if (pos_q.size() == 0) begin
				report("unexpected result", status, 0);
			end else begin
				e = pos_q.pop_front();
				if (status !== e.st) report("status", status, e.st);
				if (pos_forward_mm !== e.fwd) report("forward", pos_forward_mm, $signed(e.fwd));
				if (pos_lateral_mm !== e.lat) report("lateral", pos_lateral_mm, $signed(e.lat));
				if (pos_vertical_mm !== e.vert)
					report("vertical", pos_vertical_mm, $signed(e.vert));
			end
		end
	end

	task automatic cfg_write(input cfg_reg_t idx, input int val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= 20'(val);
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_HFOV: hfov = val & 32'hFFFF;
			REG_VFOV: vfov = val & 32'hFFFF;
			REG_BASE: base_um = val & 32'hFFFFF;
			REG_TLIM: tlim = val & 32'h7FFF;
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic drain();
		@(negedge clk);
		start <= 1'b0;
		while (pos_q.size() != 0) @(posedge clk);
		repeat (PIPE_LAT + 16) @(posedge clk);
	endtask

	int burst_left;

	// one transfer; optional gap first to shape bursts
	task automatic send(input row_t r);
		pos_t p;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 30);
			if ($urandom_range(0, 3) != 0) begin
				@(negedge clk);
				start <= 1'b0;
				repeat ($urandom_range(1, 12)) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		start <= 1'b1;
		left_fresh <= r.m.lv;
		right_fresh <= r.m.rv;
		left_peak_temp <= r.m.lt;
		right_peak_temp <= r.m.rt;
		left_col <= r.m.lc;
		left_row <= r.m.lr;
		right_col <= r.m.rc;
		right_row <= r.m.rr;
		do @(posedge clk); while (busy);
		if (r.typed) p = r.p;
		else locate(r.m, p);
		pos_q.push_back(p);
	endtask

	function automatic row_t rand_row();
		row_t r;
		int   d;
		r.typed = 1'b0;
		r.m.lv = $urandom_range(0, 15) != 0;
		r.m.rv = $urandom_range(0, 15) != 0;
		r.m.lt = 16'($urandom);
		d = $urandom_range(0, 7) == 0 ? $urandom_range(0, 65535)
			: $urandom_range(0, 2 * tlim) - tlim;
		r.m.rt = r.m.lt + 16'(d);
		r.m.lc = 16'($urandom);
		r.m.lr = 16'($urandom);
		r.m.rr = 16'($urandom);
		case ($urandom_range(0, 3))
			0: r.m.rc = r.m.lc + 16'($urandom_range(0, 64)) - 16'd32;
			1: r.m.rc = r.m.lc - 16'($urandom_range(0, 8000));
			default: r.m.rc = 16'($urandom);
		endcase
		return r;
	endfunction

	row_t dir_rows[$];

	function automatic row_t mk(logic lv, logic rv, int lt, int rt, int lc, int lr, int rc,
			int rr, logic typed = 1'b0, status_t st = ST_OK, int v = 0);
		row_t r;
		r.m = '{lv, rv, 16'(lt), 16'(rt), 16'(lc), 16'(lr), 16'(rc), 16'(rr)};
		r.typed = typed;
		r.p = '{st, 19'd0, 19'd0, 19'(v)};
		return r;
	endfunction

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		left_fresh = 1'b0;
		right_fresh = 1'b0;
		left_peak_temp = '0;
		right_peak_temp = '0;
		left_col = '0;
		left_row = '0;
		right_col = '0;
		right_row = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		errs = 0;
		burst_left = 0;
		hfov = 12800;
		vfov = 9523;
		base_um = 294000;
		tlim = 50;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		dir_rows = '{
			mk(0, 0, 0, 0, 0, 0, 0, 0, 1, ST_NONE),
			mk(1, 0, 100, 100, 40000, 30000, 20000, 30000, 1, ST_LEFT),
			mk(0, 1, 100, 100, 40000, 30000, 20000, 30000, 1, ST_RIGHT),
			mk(1, 1, 100, -100, 40000, 30000, 20000, 30000, 1, ST_TEMP),
			mk(1, 1, -32768, 32767, 0, 0, 65535, 65535, 1, ST_TEMP),
			mk(1, 1, 250, 300, 32768, 32768, 32768, 32768, 1, ST_FAR, FAR_MM),
			mk(1, 1, 32767, 32767, 65535, 65535, 65535, 0, 1, ST_FAR, FAR_MM),
			mk(1, 1, -32768, -32768, 65535, 0, 0, 65535),
			mk(1, 1, 0, 0, 0, 65535, 65535, 0),
			mk(1, 1, 300, 251, 33000, 32768, 32700, 32768),
			mk(1, 1, 300, 300, 34000, 20000, 32000, 20000),
			mk(1, 1, 300, 300, 40000, 50000, 30000, 50000),
			mk(1, 1, 300, 300, 60000, 10000, 5000, 10000),
			mk(1, 1, 300, 350, 32800, 32768, 32768, 32768)
		};
		foreach (dir_rows[i]) send(dir_rows[i]);
		drain();

		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				1: begin
					cfg_write(REG_HFOV, 46080);
					cfg_write(REG_VFOV, 46080);
					cfg_write(REG_BASE, 1000000);
					cfg_write(REG_TLIM, 32767);
				end
				2: begin
					cfg_write(REG_HFOV, 1);
					cfg_write(REG_VFOV, 1);
					cfg_write(REG_BASE, 1);
					cfg_write(REG_TLIM, 0);
					cfg_write(cfg_reg_t'(3'd6), 32'hFFFFF);
				end
				3: begin
					cfg_write(REG_HFOV, 65535);
					cfg_write(REG_VFOV, 0);
					cfg_write(REG_BASE, 0);
					cfg_write(REG_TLIM, 1000);
				end
				4: begin
					cfg_write(REG_HFOV, $urandom_range(1000, 30000));
					cfg_write(REG_VFOV, $urandom_range(1000, 30000));
					cfg_write(REG_BASE, $urandom_range(1, 1000000));
					cfg_write(REG_TLIM, $urandom_range(0, 500));
				end
				default: ;
			endcase
			for (int n = 0; n < 400; n++) begin
				send(rand_row());
				if (ph == 0 && n == 200) drain();
			end
			drain();
		end

		if (errs == 0)
			$display("stereo_angle_triangulation_top regression: pass");
		else
			$display("stereo_angle_triangulation_top regression: fail");
		$finish;
	end

endmodule
